/* design/neighbor_color_similarity_stencil_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef NEIGHBOR_COLOR_SIMILARITY_STENCIL_UNIT_ASSERT_SVH
`define NEIGHBOR_COLOR_SIMILARITY_STENCIL_UNIT_ASSERT_SVH

// same-cycle implication
`define NCSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ncss assertion failed");

// next-cycle implication
`define NCSS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ncss assertion failed");

`endif

/* design/ncss_pkg.sv */
package ncss_pkg;

    localparam int NV_W   = 17;   // normalized channel, Q6.10 signed
    localparam int SIM_W  = 16;
    localparam int DIM_W  = 14;   // frame size compare width
    localparam int PROD_W = 2 * NV_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int NRM_W  = 32;   // squared norm, unsigned
    localparam int QUO_W  = 15;   // similarity quotient bits
    localparam int NUM_W  = NRM_W + QUO_W + 1;
    localparam int REM_W  = NRM_W + 2;

    localparam logic signed [SIM_W-1:0] Q14_ONE  = 16'sd16384;
    localparam logic signed [SIM_W-1:0] MIN_INIT = 16'sd32767;

    typedef logic signed [NV_W-1:0] nval_t;
    typedef nval_t [2:0] npix_t;   // [0] blue, [1] green, [2] red

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } in_t;

    typedef struct packed {
        logic signed [SIM_W-1:0] sim_up;
        logic signed [SIM_W-1:0] sim_up_right;
        logic signed [SIM_W-1:0] sim_right;
        logic signed [SIM_W-1:0] sim_down_right;
        logic signed [SIM_W-1:0] sim_down;
        logic signed [SIM_W-1:0] sim_down_left;
        logic signed [SIM_W-1:0] sim_left;
        logic signed [SIM_W-1:0] sim_up_left;
        logic signed [SIM_W-1:0] local_max;
        logic signed [SIM_W-1:0] avg_local_max;
        logic                    is_summary;
        logic                    last_of_run;
    } res_t;

    typedef enum logic [2:0] {
        REG_MEAN_BLUE     = 3'd0,
        REG_MEAN_GREEN    = 3'd1,
        REG_MEAN_RED      = 3'd2,
        REG_INV_STD_BLUE  = 3'd3,
        REG_INV_STD_GREEN = 3'd4,
        REG_INV_STD_RED   = 3'd5,
        REG_IMAGE_WIDTH   = 3'd6,
        REG_IMAGE_HEIGHT  = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_SHIFT,
        ST_CNORM,
        ST_DOT,
        ST_NNORM,
        ST_DIVSET,
        ST_DIV,
        ST_SIMDONE,
        ST_RES,
        ST_EMIT,
        ST_CNT,
        ST_AVGSET,
        ST_AVG,
        ST_SEMIT
    } state_t;

    // window position of each neighbor, in output order (up first, clockwise)
    localparam logic [1:0] NB_ROW [8] = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0};
    localparam logic [1:0] NB_COL [8] = '{2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0};

    // Q.20 product to Q6.10: round half away from zero, saturate to 32768
    function automatic nval_t norm_round(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0]    mag;
        logic [PROD_W-1:0]    tmp;
        logic [PROD_W-11:0]   rnd;
        logic signed [NV_W-1:0] sm;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        tmp = mag + PROD_W'(512);
        rnd = tmp[PROD_W-1:10];
        if (rnd > (PROD_W-10)'(32768)) begin
            rnd = (PROD_W-10)'(32768);
        end
        sm = $signed(rnd[NV_W-1:0]);
        return p[PROD_W-1] ? -sm : sm;
    endfunction

endpackage

/* design/ncss_ram.sv */
module ncss_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/neighbor_color_similarity_stencil_unit.sv */
// A pixel that closes an interior window gives its result once the center norm and, per neighbor,
// the dot product, neighbor norm and division are done (no division where both norms are zero);
// other pixels are only normalized, stored and shifted in. One pixel is taken at a time; a single 17x17
// multiplier and a one-bit-a-cycle divider serve all eight neighbors. The frame summary
// follows the last pixel result.
// Reset (aresetn, synchronous): control, counters and frame statistics clear; line store is not.
module neighbor_color_similarity_stencil_unit
    import ncss_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output res_t        m_data
);

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int CH       = $clog2(MAX_HEIGHT);
    localparam int LS_AW    = CW + 1;
    localparam int LS_DEPTH = 2 ** LS_AW;
    localparam int SUM_W    = SIM_W + CW + CH;
    localparam int CNT_W    = CW + CH;
    localparam int STEP_W   = $clog2(SUM_W + 1);

    // configuration
    logic [15:0] mean_reg [3];
    logic [15:0] inv_reg  [3];
    logic [10:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                mean_reg[i] <= '0;
                inv_reg[i]  <= '0;
            end
            width_reg  <= 11'd3;
            height_reg <= 11'd3;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MEAN_BLUE:     mean_reg[0] <= cfg_data;
                REG_MEAN_GREEN:    mean_reg[1] <= cfg_data;
                REG_MEAN_RED:      mean_reg[2] <= cfg_data;
                REG_INV_STD_BLUE:  inv_reg[0]  <= cfg_data;
                REG_INV_STD_GREEN: inv_reg[1]  <= cfg_data;
                REG_INV_STD_RED:   inv_reg[2]  <= cfg_data;
                REG_IMAGE_WIDTH:   width_reg   <= cfg_data[10:0];
                REG_IMAGE_HEIGHT:  height_reg  <= cfg_data[10:0];
            endcase
        end
    end

    // frame size, clamped
    logic [DIM_W-1:0] w_ext, h_ext, w_dim, h_dim, w_m2, h_m2;
    assign w_ext = DIM_W'(width_reg);
    assign h_ext = DIM_W'(height_reg);
    assign w_dim = (w_ext < DIM_W'(3)) ? DIM_W'(3) :
                   (w_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_ext;
    assign h_dim = (h_ext < DIM_W'(3)) ? DIM_W'(3) :
                   (h_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_ext;
    assign w_m2  = w_dim - DIM_W'(2);
    assign h_m2  = h_dim - DIM_W'(2);

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [CW-1:0] col_reg;
    logic [CH-1:0] row_reg;
    logic          int_reg, rend_reg, fend_reg;
    in_t           pix_reg;
    npix_t         px_reg, top_reg, mid_reg;
    npix_t         win_reg [3][3];

    logic row_end, frame_end, interior;
    assign row_end   = DIM_W'(col_reg) >= (w_dim - DIM_W'(1));
    assign frame_end = row_end && (DIM_W'(row_reg) >= (h_dim - DIM_W'(1)));
    assign interior  = (row_reg >= CH'(2)) && (col_reg >= CW'(2));

    // line store: two rows, bank picked by row parity
    logic [LS_AW-1:0] ls_raddr, ls_waddr;
    logic [$bits(npix_t)-1:0] ls_rdata;
    logic ls_we;

    assign ls_raddr = {(state_reg == ST_IDLE) ? row_reg[0] : ~row_reg[0], col_reg};
    assign ls_waddr = {row_reg[0], col_reg};

    ncss_ram #(
        .WIDTH ($bits(npix_t)),
        .DEPTH (LS_DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ls_we),
        .waddr (ls_waddr),
        .wdata (px_reg),
        .raddr (ls_raddr),
        .rdata (ls_rdata)
    );

    // shared multiplier
    logic [1:0] ch_sel;
    logic [2:0] nb_reg;
    npix_t      center, nbpix;
    logic [7:0] x_ch;
    logic signed [NV_W-1:0] op_a, op_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_sum, dot_reg;

    assign ch_sel = (step_reg < STEP_W'(3)) ? step_reg[1:0] : 2'd0;
    assign center = win_reg[1][1];
    assign nbpix  = win_reg[NB_ROW[nb_reg]][NB_COL[nb_reg]];

    always_comb begin
        unique case (ch_sel)
            2'd0:    x_ch = pix_reg.blue;
            2'd1:    x_ch = pix_reg.green;
            default: x_ch = pix_reg.red;
        endcase
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_NORM: begin
                op_a = $signed({1'b0, x_ch, 8'h00}) - $signed({1'b0, mean_reg[ch_sel]});
                op_b = $signed({1'b0, inv_reg[ch_sel]});
            end
            ST_CNORM: begin
                op_a = center[ch_sel];
                op_b = center[ch_sel];
            end
            ST_DOT: begin
                op_a = center[ch_sel];
                op_b = nbpix[ch_sel];
            end
            ST_NNORM: begin
                op_a = nbpix[ch_sel];
                op_b = nbpix[ch_sel];
            end
            default: ;
        endcase
    end

    assign acc_sum = acc_reg + ACC_W'(prod_reg);

    // similarity divider
    logic [NRM_W-1:0] cn_reg, nn_reg, mx_w, mag_w;
    logic [NUM_W-1:0] numer_w;
    logic [REM_W-1:0] rem_reg, rem_sh;
    logic [NRM_W:0]   dvs_reg;
    logic [QUO_W-1:0] lo_reg, quo_reg;
    logic             zero_reg, neg_reg, div_ge;
    logic signed [ACC_W-1:0] dot_abs;

    assign mx_w    = (cn_reg > nn_reg) ? cn_reg : nn_reg;
    assign dot_abs = dot_reg[ACC_W-1] ? -dot_reg : dot_reg;
    assign mag_w   = dot_abs[NRM_W-1:0];
    assign numer_w = NUM_W'({mag_w, QUO_W'(0)}) + NUM_W'(mx_w);
    assign rem_sh  = {rem_reg[REM_W-2:0], lo_reg[QUO_W-1]};
    assign div_ge  = rem_sh >= REM_W'(dvs_reg);

    logic [QUO_W-1:0]        q_clip;
    logic signed [SIM_W-1:0] sim_w;
    assign q_clip = zero_reg ? QUO_W'(Q14_ONE) :
                    (quo_reg > QUO_W'(Q14_ONE)) ? QUO_W'(Q14_ONE) : quo_reg;
    assign sim_w  = neg_reg ? -$signed(SIM_W'(q_clip)) : $signed(SIM_W'(q_clip));

    logic signed [SIM_W-1:0] sim_reg [8];
    logic signed [SIM_W-1:0] lmax_reg, run_min_reg;
    logic signed [SUM_W-1:0] run_sum_reg;

    // summary mean divider
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] adv_reg;
    logic [CNT_W:0]   arem_reg, arem_sh;
    logic             aneg_reg, avg_ge;
    logic signed [SUM_W-1:0] sum_abs;
    logic [SIM_W-1:0]        avq;
    logic signed [SIM_W-1:0] avg_w;

    assign sum_abs = run_sum_reg[SUM_W-1] ? -run_sum_reg : run_sum_reg;
    assign arem_sh = {arem_reg[CNT_W-1:0], adv_reg[SUM_W-1]};
    assign avg_ge  = arem_sh >= {1'b0, cnt_reg};
    assign avq     = (adv_reg > SUM_W'(Q14_ONE)) ? SIM_W'(Q14_ONE) : adv_reg[SIM_W-1:0];
    assign avg_w   = aneg_reg ? -$signed(avq) : $signed(avq);

    // output word
    logic  m_valid_reg, out_free, load_pix, load_sum;
    res_t  m_data_reg, pix_res, sum_res;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        pix_res                = '0;
        pix_res.sim_up         = sim_reg[0];
        pix_res.sim_up_right   = sim_reg[1];
        pix_res.sim_right      = sim_reg[2];
        pix_res.sim_down_right = sim_reg[3];
        pix_res.sim_down       = sim_reg[4];
        pix_res.sim_down_left  = sim_reg[5];
        pix_res.sim_left       = sim_reg[6];
        pix_res.sim_up_left    = sim_reg[7];
        pix_res.local_max      = lmax_reg;
        pix_res.last_of_run    = !fend_reg;
        sum_res                = '0;
        sum_res.local_max      = run_min_reg;
        sum_res.avg_local_max  = avg_w;
        sum_res.is_summary     = 1'b1;
        sum_res.last_of_run    = 1'b1;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_NORM;
            ST_NORM:    if (step_reg == STEP_W'(3)) state_next = ST_SHIFT;
            ST_SHIFT: begin
                if (int_reg) state_next = ST_CNORM;
                else if (fend_reg) state_next = ST_CNT;
                else state_next = ST_IDLE;
            end
            ST_CNORM:   if (step_reg == STEP_W'(3)) state_next = ST_DOT;
            ST_DOT:     if (step_reg == STEP_W'(3)) state_next = ST_NNORM;
            ST_NNORM:   if (step_reg == STEP_W'(3)) state_next = ST_DIVSET;
            ST_DIVSET:  state_next = (mx_w == '0) ? ST_SIMDONE : ST_DIV;
            ST_DIV:     if (step_reg == STEP_W'(QUO_W - 1)) state_next = ST_SIMDONE;
            ST_SIMDONE: state_next = (nb_reg == 3'd7) ? ST_RES : ST_DOT;
            ST_RES:     state_next = ST_EMIT;
            ST_EMIT:    if (out_free) state_next = fend_reg ? ST_CNT : ST_IDLE;
            ST_CNT:     state_next = ST_AVGSET;
            ST_AVGSET:  state_next = ST_AVG;
            ST_AVG:     if (step_reg == STEP_W'(SUM_W - 1)) state_next = ST_SEMIT;
            ST_SEMIT:   if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready  = 1'b0;
        ls_we    = 1'b0;
        load_pix = 1'b0;
        load_sum = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready  = 1'b1;
            ST_SHIFT: ls_we    = 1'b1;
            ST_EMIT:  load_pix = out_free;
            ST_SEMIT: load_sum = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            nb_reg      <= '0;
            run_min_reg <= MIN_INIT;
            run_sum_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? '0 : step_reg + STEP_W'(1);

            if (state_reg == ST_SHIFT) begin
                if (fend_reg) begin
                    row_reg <= '0;
                    col_reg <= '0;
                end else if (rend_reg) begin
                    row_reg <= row_reg + CH'(1);
                    col_reg <= '0;
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
                nb_reg <= '0;
            end
            if (state_reg == ST_SIMDONE) begin
                nb_reg <= nb_reg + 3'd1;
            end
            if (state_reg == ST_RES) begin
                if (lmax_reg < run_min_reg) run_min_reg <= lmax_reg;
                run_sum_reg <= run_sum_reg + SUM_W'(lmax_reg);
            end
            if (load_sum) begin
                run_min_reg <= MIN_INIT;
                run_sum_reg <= '0;
            end

            if (load_pix) begin
                m_valid_reg <= 1'b1;
            end else if (load_sum) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;

        if (state_reg == ST_IDLE && s_valid) begin
            pix_reg  <= s_data;
            int_reg  <= interior;
            rend_reg <= row_end;
            fend_reg <= frame_end;
        end

        if (state_reg == ST_NORM) begin
            if (step_reg == STEP_W'(0)) top_reg <= npix_t'(ls_rdata);
            if (step_reg == STEP_W'(1)) mid_reg <= npix_t'(ls_rdata);
            if (step_reg != STEP_W'(0)) px_reg[step_reg[1:0] - 2'd1] <= norm_round(prod_reg);
        end

        if (state_reg == ST_SHIFT) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_reg;
            win_reg[1][2] <= mid_reg;
            win_reg[2][2] <= px_reg;
            lmax_reg      <= -Q14_ONE;
        end

        if (state_reg == ST_CNORM || state_reg == ST_DOT || state_reg == ST_NNORM) begin
            if (step_reg == STEP_W'(0)) begin
                acc_reg <= '0;
            end else begin
                acc_reg <= acc_sum;
            end
            if (step_reg == STEP_W'(3)) begin
                unique case (state_reg)
                    ST_CNORM: cn_reg  <= acc_sum[NRM_W-1:0];
                    ST_DOT:   dot_reg <= acc_sum;
                    default:  nn_reg  <= acc_sum[NRM_W-1:0];
                endcase
            end
        end

        if (state_reg == ST_DIVSET) begin
            rem_reg  <= REM_W'(numer_w[NUM_W-1:QUO_W]);
            lo_reg   <= numer_w[QUO_W-1:0];
            dvs_reg  <= {mx_w, 1'b0};
            zero_reg <= (mx_w == '0);
            neg_reg  <= dot_reg[ACC_W-1];
            quo_reg  <= '0;
        end

        if (state_reg == ST_DIV) begin
            rem_reg <= div_ge ? (rem_sh - REM_W'(dvs_reg)) : rem_sh;
            lo_reg  <= {lo_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
        end

        if (state_reg == ST_SIMDONE) begin
            sim_reg[nb_reg] <= sim_w;
            if (sim_w > lmax_reg) lmax_reg <= sim_w;
        end

        if (state_reg == ST_CNT) begin
            cnt_reg <= w_m2[CW-1:0] * h_m2[CH-1:0];
        end

        if (state_reg == ST_AVGSET) begin
            adv_reg  <= sum_abs;
            aneg_reg <= run_sum_reg[SUM_W-1];
            arem_reg <= '0;
        end

        if (state_reg == ST_AVG) begin
            arem_reg <= avg_ge ? (arem_sh - {1'b0, cnt_reg}) : arem_sh;
            adv_reg  <= {adv_reg[SUM_W-2:0], avg_ge};
        end

        if (load_pix) begin
            m_data_reg <= pix_res;
        end else if (load_sum) begin
            m_data_reg <= sum_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/ncss_checker.sv */
`include "neighbor_color_similarity_stencil_unit_assert.svh"

module ncss_checker
    import ncss_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input res_t m_data
);

    logic sum_ok, max_ok;

    assign sum_ok = m_data.last_of_run && m_data.sim_up == 16'sd0 && m_data.sim_left == 16'sd0;
    assign max_ok = m_data.avg_local_max == 16'sd0 &&
                    m_data.local_max >= m_data.sim_up &&
                    m_data.local_max >= m_data.sim_up_right &&
                    m_data.local_max >= m_data.sim_right &&
                    m_data.local_max >= m_data.sim_down_right &&
                    m_data.local_max >= m_data.sim_down &&
                    m_data.local_max >= m_data.sim_down_left &&
                    m_data.local_max >= m_data.sim_left &&
                    m_data.local_max >= m_data.sim_up_left;

    `NCSS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // one pixel at a time: a taken word drops ready
    `NCSS_ASSERT_NXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready)

    `NCSS_ASSERT_IMP(a_summary_shape, aclk, aresetn, m_valid && m_data.is_summary, sum_ok)

    `NCSS_ASSERT_IMP(a_local_max, aclk, aresetn, m_valid && !m_data.is_summary, max_ok)

endmodule

bind neighbor_color_similarity_stencil_unit ncss_checker u_ncss_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import ncss_pkg::*;

    localparam int FRAME_W_MAX = 1024;
    localparam int FRAME_H_MAX = 1024;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_CYC   = 250;
    localparam int SETTLE_CYC  = 12;

    // all-zero vectors: every neighbor counts as identical
    localparam res_t ONE_PIX = '{Q14_ONE, Q14_ONE, Q14_ONE, Q14_ONE, Q14_ONE, Q14_ONE,
                                 Q14_ONE, Q14_ONE, Q14_ONE, 16'sd0, 1'b0, 1'b0};
    localparam res_t ONE_SUM = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                 16'sd0, 16'sd0, Q14_ONE, Q14_ONE, 1'b1, 1'b1};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    res_t        m_data;

    neighbor_color_similarity_stencil_unit #(
        .MAX_WIDTH (FRAME_W_MAX),
        .MAX_HEIGHT(FRAME_H_MAX)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #10 aclk = ~aclk;

    // shadow of the block's registers and frame state
    int     cfg_reg [8];
    int     line_mem [2][FRAME_W_MAX][3];
    int     win [3][3][3];
    int     row_cnt;
    int     col_cnt;
    int     min_peak;
    longint sum_peak;
    res_t   sim_q [$];
    int     errors;
    bit     calm;
    int     idle_cnt;

    typedef struct {
        bit          is_cfg;
        reg_idx_t    idx;
        logic [15:0] val;
        in_t         px;
        int          ntyped;
        res_t        t0;
        res_t        t1;
    } dir_row_t;

    dir_row_t dir_tab [$];

    function automatic int clamp_dim(int v, int hi);
        return v < 3 ? 3 : (v > hi ? hi : v);
    endfunction

    function automatic int norm_ch(int x, int mean, int inv);
        longint d, p, mag;
        d = longint'(x) * 256 - mean;
        p = d * inv;
        mag = p < 0 ? -p : p;
        mag = (mag + 512) / 1024;
        if (mag > 32768) mag = 32768;
        return p < 0 ? -int'(mag) : int'(mag);
    endfunction

    // similarity of the window center to window cell (rr, cc)
    function automatic int sim_nb(int rr, int cc);
        longint na, nb, mx, dot, mag, q;
        na = 0;
        nb = 0;
        dot = 0;
        for (int k = 0; k < 3; k++) begin
            na += longint'(win[1][1][k]) * win[1][1][k];
            nb += longint'(win[rr][cc][k]) * win[rr][cc][k];
            dot += longint'(win[1][1][k]) * win[rr][cc][k];
        end
        mx = na > nb ? na : nb;
        if (mx == 0) return 16384;
        mag = dot < 0 ? -dot : dot;
        q = (2 * mag * 16384 + mx) / (2 * mx);
        if (q > 16384) q = 16384;
        return dot < 0 ? -int'(q) : int'(q);
    endfunction

    task automatic predict_word(input in_t p);
        int     w, h, r, c, ci, mx, s, nbr_r, nbr_c;
        int     px [3];
        int     sv [8];
        int     dr [8];
        int     dc [8];
        bit     row_end, frame_end;
        longint avg;
        res_t   o;
        dr = '{-1, -1, 0, 1, 1, 1, 0, -1};
        dc = '{0, 1, 1, 1, 0, -1, -1, -1};
        w = clamp_dim(cfg_reg[REG_IMAGE_WIDTH], FRAME_W_MAX);
        h = clamp_dim(cfg_reg[REG_IMAGE_HEIGHT], FRAME_H_MAX);
        r = row_cnt;
        c = col_cnt;
        ci = c < FRAME_W_MAX ? c : FRAME_W_MAX - 1;
        row_end = c >= w - 1;
        frame_end = row_end && r >= h - 1;
        px[0] = norm_ch(p.blue, cfg_reg[REG_MEAN_BLUE], cfg_reg[REG_INV_STD_BLUE]);
        px[1] = norm_ch(p.green, cfg_reg[REG_MEAN_GREEN], cfg_reg[REG_INV_STD_GREEN]);
        px[2] = norm_ch(p.red, cfg_reg[REG_MEAN_RED], cfg_reg[REG_INV_STD_RED]);
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                win[i][0][k] = win[i][1][k];
                win[i][1][k] = win[i][2][k];
            end
            win[0][2][k] = line_mem[r & 1][ci][k];
            win[1][2][k] = line_mem[(r + 1) & 1][ci][k];
            win[2][2][k] = px[k];
            line_mem[r & 1][ci][k] = px[k];
        end
        if (r >= 2 && c >= 2) begin
            mx = -16384;
            for (int k = 0; k < 8; k++) begin
                nbr_r = 1 + dr[k];
                nbr_c = 1 + dc[k];
                s = sim_nb(nbr_r, nbr_c);
                sv[k] = s;
                if (s > mx) mx = s;
            end
            o.sim_up = 16'(sv[0]);
            o.sim_up_right = 16'(sv[1]);
            o.sim_right = 16'(sv[2]);
            o.sim_down_right = 16'(sv[3]);
            o.sim_down = 16'(sv[4]);
            o.sim_down_left = 16'(sv[5]);
            o.sim_left = 16'(sv[6]);
            o.sim_up_left = 16'(sv[7]);
            o.local_max = 16'(mx);
            o.avg_local_max = '0;
            o.is_summary = 1'b0;
            o.last_of_run = !frame_end;
            sim_q = {sim_q, o};
            if (mx < min_peak) min_peak = mx;
            sum_peak += mx;
        end
        if (row_end) begin
            col_cnt = 0;
            row_cnt = r + 1;
        end else begin
            col_cnt = c + 1;
        end
        if (frame_end) begin
            avg = sum_peak / (longint'(w - 2) * (h - 2));
            if (avg > 16384) avg = 16384;
            if (avg < -16384) avg = -16384;
            o = '0;
            o.local_max = 16'(min_peak);
            o.avg_local_max = 16'(avg);
            o.is_summary = 1'b1;
            o.last_of_run = 1'b1;
            sim_q = {sim_q, o};
            row_cnt = 0;
            col_cnt = 0;
            min_peak = 32767;
            sum_peak = 0;
        end
    endtask

    task automatic send_px(input in_t p);
        int g;
        g = calm ? 0 : $urandom_range(0, 19);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // registers change only with the block drained
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sim_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic wr_cfg(input reg_idx_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_reg[idx] = idx < REG_IMAGE_WIDTH ? int'(val) : int'(val & 16'h07FF);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic dir_row_t blank_row();
        dir_row_t d;
        d.is_cfg = 1'b0;
        d.idx = REG_MEAN_BLUE;
        d.val = '0;
        d.px = '0;
        d.ntyped = 0;
        d.t0 = '0;
        d.t1 = '0;
        return d;
    endfunction

    task automatic add_cfg(input reg_idx_t idx, input logic [15:0] val);
        dir_row_t d;
        d = blank_row();
        d.is_cfg = 1'b1;
        d.idx = idx;
        d.val = val;
        dir_tab = {dir_tab, d};
    endtask

    task automatic add_px(input in_t p);
        dir_row_t d;
        d = blank_row();
        d.px = p;
        dir_tab = {dir_tab, d};
    endtask

    task automatic push_word(input in_t p);
        send_px(p);
        predict_word(p);
    endtask

    function automatic logic [15:0] rand_reg16();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 16'h3000));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stim
        in_t      p, prev;
        int       n0, items, fw, fh, mode;
        dir_row_t d;
        errors = 0;
        calm = 1'b0;
        cfg_reg = '{0, 0, 0, 0, 0, 0, 3, 3};
        row_cnt = 0;
        col_cnt = 0;
        min_peak = 32767;
        sum_peak = 0;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < FRAME_W_MAX; j++)
                for (int k = 0; k < 3; k++) line_mem[i][j][k] = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++) win[i][j][k] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: inv_std zero, so all-one results regardless of input
        add_px('{8'h00, 8'h00, 8'h00});
        add_px('{8'hFF, 8'hFF, 8'hFF});
        add_px('{8'hFF, 8'h00, 8'h00});
        add_px('{8'h00, 8'hFF, 8'h00});
        add_px('{8'h00, 8'h00, 8'hFF});
        add_px('{8'hFF, 8'hFF, 8'h00});
        add_px('{8'h00, 8'hFF, 8'hFF});
        add_px('{8'hFF, 8'h00, 8'hFF});
        add_px('{8'h55, 8'hAA, 8'h0F});
        dir_tab[dir_tab.size() - 1].ntyped = 2;
        dir_tab[dir_tab.size() - 1].t0 = ONE_PIX;
        dir_tab[dir_tab.size() - 1].t1 = ONE_SUM;
        // extreme scaling, then shrink width in the middle of row 2
        add_cfg(REG_MEAN_BLUE, 16'hFFFF);
        add_cfg(REG_MEAN_GREEN, 16'h8000);
        add_cfg(REG_MEAN_RED, 16'h0000);
        add_cfg(REG_INV_STD_BLUE, 16'hFFFF);
        add_cfg(REG_INV_STD_GREEN, 16'h1000);
        add_cfg(REG_INV_STD_RED, 16'h0000);
        add_cfg(REG_IMAGE_WIDTH, 16'd5);
        add_cfg(REG_IMAGE_HEIGHT, 16'd3);
        for (int i = 0; i < 13; i++)
            add_px('{8'(i * 37 + 3), 8'(i * 91), 8'(255 - i * 13)});
        add_cfg(REG_IMAGE_WIDTH, 16'd3);
        add_px('{8'hFF, 8'h80, 8'h00});

        foreach (dir_tab[i]) begin
            d = dir_tab[i];
            if (d.is_cfg) begin
                wait_drained();
                wr_cfg(d.idx, d.val);
            end else begin
                n0 = sim_q.size();
                push_word(d.px);
                if (d.ntyped > 0) begin
                    while (sim_q.size() > n0) void'(sim_q.pop_back());
                    sim_q = {sim_q, d.t0};
                    if (d.ntyped > 1) sim_q = {sim_q, d.t1};
                end
            end
        end

        // random frames, small sizes
        items = 0;
        prev = '0;
        while (items < 1000) begin
            wait_drained();
            calm = $urandom_range(0, 3) == 0;
            for (int k = 0; k < 6; k++) wr_cfg(reg_idx_t'(k), rand_reg16());
            fw = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 12);
            fh = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 6);
            wr_cfg(REG_IMAGE_WIDTH, 16'(fw));
            wr_cfg(REG_IMAGE_HEIGHT, 16'(fh));
            for (int i = 0; i < clamp_dim(fw, FRAME_W_MAX) * clamp_dim(fh, FRAME_H_MAX); i++) begin
                mode = $urandom_range(0, 9);
                if (mode < 7) begin
                    p = in_t'($urandom);
                end else if (mode < 9) begin
                    p = prev;
                end else begin
                    // sits on the mean: near-zero vectors
                    p = '{8'(cfg_reg[REG_MEAN_BLUE] >> 8), 8'(cfg_reg[REG_MEAN_GREEN] >> 8),
                          8'(cfg_reg[REG_MEAN_RED] >> 8)};
                end
                push_word(p);
                prev = p;
                items++;
            end
        end
        calm = 1'b0;

        s_valid <= 1'b0;
        while (sim_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (errors == 0 && sim_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : sink
        int g;
        forever begin
            g = calm ? 0 : $urandom_range(0, 19);
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic void res_fields(input res_t r, output int f [12]);
        f = '{r.sim_up, r.sim_up_right, r.sim_right, r.sim_down_right, r.sim_down,
              r.sim_down_left, r.sim_left, r.sim_up_left, r.local_max, r.avg_local_max,
              r.is_summary, r.last_of_run};
    endfunction

    always @(posedge aclk) begin : check
        res_t  e;
        int    fe [12];
        int    fa [12];
        string nm [12];
        nm = '{"sim_up", "sim_up_right", "sim_right", "sim_down_right", "sim_down",
               "sim_down_left", "sim_left", "sim_up_left", "local_max", "avg_local_max",
               "is_summary", "last_of_run"};
        if (aresetn && m_valid && m_ready) begin
            if (sim_q.size() == 0) begin
                if (errors < 10) $display("unexpected result word %h", m_data);
                errors++;
            end else begin
                e = sim_q[0];
                sim_q.delete(0);
                res_fields(e, fe);
                res_fields(m_data, fa);
                for (int k = 0; k < 12; k++) begin
                    if (^m_data === 1'bx || fe[k] != fa[k]) begin
                        if (errors < 10)
                            $display("%s: expected %0d, got %0d", nm[k], fe[k], fa[k]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial idle_cnt = 0;

endmodule

/* neighbor_color_similarity_stencil_unit.f */
+incdir+design
design/ncss_pkg.sv
design/ncss_ram.sv
design/neighbor_color_similarity_stencil_unit.sv
design/ncss_checker.sv
tb/sv/testbench.sv
